@@ rtl/slt_pkg.sv @@
// Package: shared constants and types for the serial-commanded LED timer.
`timescale 1ns / 1ps

package slt_pkg;

	// Frame and LED geometry
	localparam int FRAME_BYTES = 2;
	localparam int LED_COUNT   = 4;
	localparam int LED_W       = 4;
	localparam int TIMER_W     = 8;
	localparam int TICK_W      = 16;
	localparam int POS_W       = 4;
	localparam int BYTE_W      = 8;

	// Prescaler reset: ticks in one second
	localparam logic [TICK_W-1:0] TPS_RESET = 16'd31250;

	// Event kinds on the input channel
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Command letters
	localparam logic [BYTE_W-1:0] CMD_LOAD_FIRST   = 8'h61; // 'a'
	localparam logic [BYTE_W-1:0] CMD_LOAD_LAST    = 8'h64; // 'd'
	localparam logic [BYTE_W-1:0] CMD_TOGGLE_FIRST = 8'h41; // 'A'
	localparam logic [BYTE_W-1:0] CMD_TOGGLE_LAST  = 8'h44; // 'D'

	typedef logic [TIMER_W-1:0] timer_t;

endpackage

@@ rtl/serial_commanded_led_timer.sv @@
// Top level: serial command frames drive four LEDs, each with an off-timer in seconds.
`timescale 1ns / 1ps

// Takes one event per cycle while in_stall is low: a received byte (op 0)
// or a timer overflow tick (op 1), and returns one result per event with the
// LED outputs after it. An accepted event is held in an input register; the
// next stage updates prescaler, frame assembly, command decode and all four
// timers in parallel and loads the result register, so a new event is taken
// every cycle while not stalled, and a result is offered once it has moved
// from the input register into the result register. The output register
// decouples the sides: the block keeps taking events while a result waits,
// and stalls only when both stages are full and the result is stalled.
// Two-byte frames: a lowercase letter a-d toggles its LED and loads its
// timer from the second byte, uppercase A-D only toggles. ticks_per_second
// is written through the cfg port, which is always ready, and is meant to
// change only while idle.
module serial_commanded_led_timer (
	input  logic                         clk,
	input  logic                         arst_n,
	// event channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [slt_pkg::BYTE_W-1:0]   rx_byte,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [slt_pkg::LED_W-1:0]    led_state,
	output logic                         second_pulse,
	output logic                         frame_done,
	// ticks_per_second write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [slt_pkg::TICK_W-1:0]   cfg_data
);

	import slt_pkg::*;

	// Input stage
	logic              valid_s1;
	op_t               op_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Result stage
	logic              valid_s2;
	logic [LED_W-1:0]  led_s2;
	logic              pulse_s2;
	logic              done_s2;

	// Block state
	logic [TICK_W-1:0] tps_q;
	logic [TICK_W-1:0] tick_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] frame_q [2];
	timer_t            timer_q [LED_COUNT];
	logic [LED_W-1:0]  led_q;

	// Next-state values
	logic [TICK_W-1:0] tick_inc;
	logic [TICK_W-1:0] tick_d;
	logic [POS_W-1:0]  pos_d;
	timer_t            timer_d [LED_COUNT];
	timer_t            timer_dec;
	logic [LED_W-1:0]  led_d;
	logic              pulse_d;
	logic              done_d;
	logic              last_byte;
	logic [BYTE_W-1:0] cmd_byte;
	logic [BYTE_W-1:0] arg_byte;
	logic              is_load;
	logic              is_toggle;
	logic [1:0]        cmd_idx;
	logic              store_wr;

	// Handshake
	logic s2_ready;
	logic adv_s1;

	assign s2_ready  = !valid_s2 || !out_stall;
	assign adv_s1    = valid_s1 && s2_ready;
	assign in_stall  = valid_s1 && !s2_ready;
	assign cfg_ready = 1'b1;

	assign out_valid    = valid_s2;
	assign led_state    = led_s2;
	assign second_pulse = pulse_s2;
	assign frame_done   = done_s2;

	// Frame bookkeeping
	assign last_byte = (pos_q == POS_W'(FRAME_BYTES - 1));
	assign store_wr  = (pos_q < POS_W'(2));
	assign cmd_byte  = frame_q[0];
	assign arg_byte  = (pos_q == POS_W'(1)) ? byte_s1 : frame_q[1];
	assign is_load   = (cmd_byte >= CMD_LOAD_FIRST) && (cmd_byte <= CMD_LOAD_LAST);
	assign is_toggle = (cmd_byte >= CMD_TOGGLE_FIRST) && (cmd_byte <= CMD_TOGGLE_LAST);
	assign cmd_idx   = is_load ? 2'(cmd_byte - CMD_LOAD_FIRST)
	                           : 2'(cmd_byte - CMD_TOGGLE_FIRST);

	// Prescaler
	assign tick_inc = tick_q + TICK_W'(1);

	// Per-event update: tick path or byte path
	always_comb begin
		tick_d  = tick_q;
		pos_d   = pos_q;
		led_d   = led_q;
		pulse_d = 1'b0;
		done_d  = 1'b0;
		timer_dec = '0;
		for (int i = 0; i < LED_COUNT; i++) begin
			timer_d[i] = timer_q[i];
		end
		case (op_s1)
			OP_TICK: begin
				if (tick_inc == tps_q) begin
					tick_d  = '0;
					pulse_d = 1'b1;
					// one second: nonzero timers count down, expiry forces LED off
					for (int i = 0; i < LED_COUNT; i++) begin
						if (timer_q[i] != '0) begin
							timer_dec  = timer_q[i] - TIMER_W'(1);
							timer_d[i] = timer_dec;
							if (timer_dec == '0) begin
								led_d[i] = 1'b0;
							end
						end
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			OP_BYTE: begin
				if (last_byte) begin
					pos_d  = '0;
					done_d = 1'b1;
					if ((is_load || is_toggle) && ({1'b0, cmd_idx} < 3'(LED_COUNT))) begin
						led_d[cmd_idx] = !led_q[cmd_idx];
						if (is_load) begin
							timer_d[cmd_idx] = arg_byte;
						end
					end
				end else begin
					pos_d = pos_q + POS_W'(1);
				end
			end
			default: begin
				tick_d = tick_q;
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op_t'(op);
			byte_s1 <= rx_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			led_s2   <= led_d;
			pulse_s2 <= pulse_d;
			done_s2  <= done_d;
		end
	end

	// Control state and timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q  <= TPS_RESET;
			tick_q <= '0;
			pos_q  <= '0;
			led_q  <= '0;
			for (int i = 0; i < LED_COUNT; i++) begin
				timer_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				tps_q <= cfg_data;
			end
			if (adv_s1) begin
				tick_q <= tick_d;
				pos_q  <= pos_d;
				led_q  <= led_d;
				for (int i = 0; i < LED_COUNT; i++) begin
					timer_q[i] <= timer_d[i];
				end
			end
		end
	end

	// Frame byte store, first two bytes only
	always_ff @(posedge clk) begin
		if (adv_s1 && (op_s1 == OP_BYTE) && store_wr) begin
			frame_q[pos_q[0]] <= byte_s1;
		end
	end

endmodule
